@@ src/avdac_pkg.sv @@
`timescale 1ns / 1ps

package avdac_pkg;

  // Field widths
  localparam int ADC_W       = 10;
  localparam int REG_W       = 16;
  localparam int MEAS_W      = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF = 255;
  localparam int DEADBAND_DEF    = 1;

  // Register reset values
  localparam logic [REG_W-1:0] TARGET_RST = 16'd0;
  localparam logic [REG_W-1:0] VFS_RST    = 16'd2500;
  localparam logic [ADC_W-1:0] AFC_RST    = 10'd1023;
  localparam logic [ADC_W-1:0] LIMIT_RST  = 10'd1023;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET = 2'd0,
    REG_VFS    = 2'd1,
    REG_AFC    = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

  // Input kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADV,
    S_DIVV,
    S_LOADC,
    S_DIVC,
    S_MUL,
    S_DIVS,
    S_OUT
  } state_t;

endpackage

@@ src/averaged_voltage_dac_stepper_unit.sv @@
`timescale 1ns / 1ps

// Averaged voltage DAC stepper.
// Input stream (in_*): one beat per ADC conversion or control tick. in_tuser
// is the kind (0 sample, 1 tick), in_tdata[9:0] the ADC sample. Samples go
// alternately to the voltage and current channel, voltage first.
// A sample beat gives no result; in_tready stays high.
// A tick beat starts the sequencer: average of each non-empty channel,
// scaling of the voltage average, then one DAC step toward the target.
// All three divisions run on one restoring divider, one quotient bit per
// cycle, DIV_W bits each (26 at default parameters). A tick steps through
// LOADV, DIVV, LOADC, DIVC, MUL, DIVS and OUT; an empty channel skips its
// division, a zero AFC skips DIVS. in_tready is low until back in idle.
// Output stream (out_*): one beat per tick, held in an output register.
// Samples are still taken while a result waits; a following tick runs its
// arithmetic and waits in its last state until the output register is free.
// Config port (cfg_*): always ready; write only while the block is idle.
// Reset (rst_n low, synchronous) clears sums, counts, averages, the DAC
// code and the output valid, and loads register defaults.
module averaged_voltage_dac_stepper_unit #(
  parameter int MAX_SAMPLES = avdac_pkg::MAX_SAMPLES_DEF,
  parameter int DEADBAND    = avdac_pkg::DEADBAND_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [avdac_pkg::IN_TDATA_W-1:0]     in_tdata,   // [9:0] sample
  input  logic                                 in_tuser,   // [0] op
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [9:0] dac_code, [19:10] avg_voltage_raw, [29:20] avg_current_raw,
  // [45:30] measured_volts
  output logic [avdac_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [avdac_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [avdac_pkg::REG_W-1:0]          cfg_data
);
  import avdac_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = CNT_W + ADC_W;
  localparam int DEN_W  = (CNT_W > ADC_W) ? CNT_W : ADC_W;
  localparam int PROD_W = ADC_W + REG_W;
  localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int CMP_W  = MEAS_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // config registers
  logic [REG_W-1:0] target_r, vfs_r;
  logic [ADC_W-1:0] afc_r, limit_r;

  // control and channel state
  state_t           state_r, state_nxt;
  logic             chan_cur_r, chan_cur_nxt;
  logic [SUM_W-1:0] volt_sum_r, volt_sum_nxt, curr_sum_r, curr_sum_nxt;
  logic [CNT_W-1:0] volt_cnt_r, volt_cnt_nxt, curr_cnt_r, curr_cnt_nxt;
  logic [ADC_W-1:0] volt_avg_r, volt_avg_nxt, curr_avg_r, curr_avg_nxt;
  logic [ADC_W-1:0] drive_r, drive_nxt;
  logic [MEAS_W-1:0] meas_r, meas_nxt;

  // shared divider
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt, den_r, den_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              fit, div_last;
  logic [DEN_W-1:0]  rem_step;
  logic [DIV_W-1:0]  quo_step;
  logic [MEAS_W-1:0] meas_sat;
  logic [PROD_W-1:0] prod;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // handshakes
  logic in_acc, slot_free, deliver, hi, lo;

  // divider step: shift one dividend bit into the remainder, trial subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, den_r};
    fit      = ~diff[DEN_W+1];
    rem_step = fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_step = {quo_r[DIV_W-2:0], fit};
    div_last = (step_r == STEP_W'(DIV_W - 1));
    meas_sat = (|quo_step[DIV_W-1:MEAS_W]) ? {MEAS_W{1'b1}} : quo_step[MEAS_W-1:0];
    prod     = PROD_W'(volt_avg_r) * PROD_W'(vfs_r);
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    cfg_ready = 1'b1;
    in_acc    = in_tvalid && in_tready;
    slot_free = !out_valid_r || out_tready;
    deliver   = (state_r == S_OUT) && slot_free;
    hi        = {1'b0, meas_r} > ({1'b0, target_r} + CMP_W'(DEADBAND));
    lo        = ({1'b0, meas_r} + CMP_W'(DEADBAND)) < {1'b0, target_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && (in_tuser == OP_TICK)) state_nxt = S_LOADV;
      S_LOADV: state_nxt = (volt_cnt_r != '0) ? S_DIVV : S_LOADC;
      S_DIVV:  if (div_last) state_nxt = S_LOADC;
      S_LOADC: state_nxt = (curr_cnt_r != '0) ? S_DIVC : S_MUL;
      S_DIVC:  if (div_last) state_nxt = S_MUL;
      S_MUL:   state_nxt = (afc_r == '0) ? S_OUT : S_DIVS;
      S_DIVS:  if (div_last) state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    chan_cur_nxt  = chan_cur_r;
    volt_sum_nxt  = volt_sum_r;
    volt_cnt_nxt  = volt_cnt_r;
    curr_sum_nxt  = curr_sum_r;
    curr_cnt_nxt  = curr_cnt_r;
    volt_avg_nxt  = volt_avg_r;
    curr_avg_nxt  = curr_avg_r;
    drive_nxt     = drive_r;
    meas_nxt      = meas_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == OP_SAMPLE)) begin
          chan_cur_nxt = !chan_cur_r;
          if (chan_cur_r) begin
            if (curr_cnt_r < CNT_MAX) begin
              curr_sum_nxt = curr_sum_r + SUM_W'(in_tdata[ADC_W-1:0]);
              curr_cnt_nxt = curr_cnt_r + 1'b1;
            end
          end else begin
            if (volt_cnt_r < CNT_MAX) begin
              volt_sum_nxt = volt_sum_r + SUM_W'(in_tdata[ADC_W-1:0]);
              volt_cnt_nxt = volt_cnt_r + 1'b1;
            end
          end
        end
      end
      S_LOADV: begin
        quo_nxt  = DIV_W'(volt_sum_r);
        den_nxt  = DEN_W'(volt_cnt_r);
        rem_nxt  = '0;
        step_nxt = '0;
      end
      S_LOADC: begin
        quo_nxt  = DIV_W'(curr_sum_r);
        den_nxt  = DEN_W'(curr_cnt_r);
        rem_nxt  = '0;
        step_nxt = '0;
      end
      S_DIVV, S_DIVC, S_DIVS: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 1'b1;
        if (div_last) begin
          if (state_r == S_DIVV) begin
            volt_avg_nxt = quo_step[ADC_W-1:0];
            volt_sum_nxt = '0;
            volt_cnt_nxt = '0;
          end else if (state_r == S_DIVC) begin
            curr_avg_nxt = quo_step[ADC_W-1:0];
            curr_sum_nxt = '0;
            curr_cnt_nxt = '0;
          end else begin
            meas_nxt = meas_sat;
          end
        end
      end
      S_MUL: begin
        // product lands straight in the dividend register
        quo_nxt  = DIV_W'(prod);
        den_nxt  = DEN_W'(afc_r);
        rem_nxt  = '0;
        step_nxt = '0;
        if (afc_r == '0) meas_nxt = {MEAS_W{1'b1}};
      end
      S_OUT: begin
        if (slot_free) begin
          if (hi) begin
            if (drive_r != '0) drive_nxt = drive_r - 1'b1;
          end else if (lo) begin
            if (drive_r < limit_r) drive_nxt = drive_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, meas_r, curr_avg_r, volt_avg_r, drive_nxt};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_cur_r  <= 1'b0;
      volt_sum_r  <= '0;
      volt_cnt_r  <= '0;
      curr_sum_r  <= '0;
      curr_cnt_r  <= '0;
      volt_avg_r  <= '0;
      curr_avg_r  <= '0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_cur_r  <= chan_cur_nxt;
      volt_sum_r  <= volt_sum_nxt;
      volt_cnt_r  <= volt_cnt_nxt;
      curr_sum_r  <= curr_sum_nxt;
      curr_cnt_r  <= curr_cnt_nxt;
      volt_avg_r  <= volt_avg_nxt;
      curr_avg_r  <= curr_avg_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      vfs_r    <= VFS_RST;
      afc_r    <= AFC_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_addr))
        REG_TARGET: target_r <= cfg_data;
        REG_VFS:    vfs_r    <= cfg_data;
        REG_AFC:    afc_r    <= cfg_data[ADC_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a tick makes the block busy on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_TICK)) |=> !in_tready)
    else $error("tick accepted but input still ready");

  // every sample flips the channel selection, full window or not
  a_chan_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_SAMPLE)) |=> (chan_cur_r != $past(chan_cur_r)))
    else $error("channel selection did not alternate");

  // sample counts never pass the window size
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (volt_cnt_r <= CNT_MAX) && (curr_cnt_r <= CNT_MAX))
    else $error("sample count beyond window");

  // DAC code moves by at most one step per result
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |=> ((drive_r == $past(drive_r)) ||
                 (drive_r == ADC_W'($past(drive_r) + 1'b1)) ||
                 (drive_r == ADC_W'($past(drive_r) - 1'b1))))
    else $error("DAC code jumped by more than one");

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && (out_data_r == $past(out_data_r))))
    else $error("pending result overwritten");

endmodule

@@ tb/sv/averaged_voltage_dac_stepper_unit_tb.sv @@
`timescale 1ns / 1ps

module averaged_voltage_dac_stepper_unit_tb;
  import avdac_pkg::*;

  // Timing budget
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLDOFF_CYCLES  = 400;   // long receiver stall
  localparam int STALL_LIMIT     = 3000;  // cycles without an input or config beat
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 190;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  // One output beat, packed to match out_tdata (dac_code in the low bits)
  typedef struct packed {
    logic [MEAS_W-1:0] volts;   // [45:30]
    logic [ADC_W-1:0]  c_avg;   // [29:20]
    logic [ADC_W-1:0]  v_avg;   // [19:10]
    logic [ADC_W-1:0]  code;    // [9:0]
  } dac_report_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [9:0] sample
  logic                   in_tuser   = 1'b0; // [0] op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [9:0] code, [19:10] v avg,
                                             // [29:20] i avg, [45:30] volts
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  reg_idx_t               cfg_addr   = REG_TARGET;
  logic [REG_W-1:0]       cfg_data   = '0;

  always #5 clk = ~clk;

  averaged_voltage_dac_stepper_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Stepper predictor: own copy of the accumulators, averages and DAC code
  // ---------------------------------------------------------------------------
  logic              on_current;
  logic [17:0]       volt_acc, curr_acc;
  logic [7:0]        volt_n, curr_n;
  logic [ADC_W-1:0]  volt_mean, curr_mean, dac_now;
  logic [REG_W-1:0]  set_target, set_vfs;
  logic [ADC_W-1:0]  set_afc, set_limit;

  dac_report_t reports_due[$];   // pending tick results, oldest first
  int unsigned mismatches   = 0;
  int          burst_left   = 1;
  int          holdoff_left = 0;
  int          holdoff_reqs = 0;  // bumped by the tests to ask for a long stall
  int          holdoff_seen = 0;

  function automatic void clear_stepper();
    on_current = 1'b0;
    volt_acc   = '0;
    curr_acc   = '0;
    volt_n     = '0;
    curr_n     = '0;
    volt_mean  = '0;
    curr_mean  = '0;
    dac_now    = '0;
    set_target = TARGET_RST;
    set_vfs    = VFS_RST;
    set_afc    = AFC_RST;
    set_limit  = LIMIT_RST;
  endfunction

  // Applies one accepted input beat; a tick queues the result it must produce.
  function automatic void advance_stepper(input logic op, input logic [ADC_W-1:0] smp);
    longint      scaled;
    int unsigned volts;
    dac_report_t rpt;
    if (op == OP_SAMPLE) begin
      // full window: sample dropped, but the channel still alternates
      if (on_current) begin
        if (curr_n < MAX_SAMPLES_DEF) begin
          curr_acc += smp;
          curr_n++;
        end
      end else if (volt_n < MAX_SAMPLES_DEF) begin
        volt_acc += smp;
        volt_n++;
      end
      on_current = !on_current;
      return;
    end
    // empty channel keeps its previous average
    if (volt_n != 0) begin
      volt_mean = ADC_W'(volt_acc / volt_n);
      volt_acc  = '0;
      volt_n    = '0;
    end
    if (curr_n != 0) begin
      curr_mean = ADC_W'(curr_acc / curr_n);
      curr_acc  = '0;
      curr_n    = '0;
    end
    if (set_afc == 0) begin
      volts = 32'hFFFF;
    end else begin
      scaled = longint'(volt_mean) * longint'(set_vfs) / longint'(set_afc);
      volts  = (scaled > 64'hFFFF) ? 32'hFFFF : int'(scaled);
    end
    if (volts > set_target + DEADBAND_DEF) begin
      if (dac_now != 0) dac_now--;
    end else if (volts + DEADBAND_DEF < set_target) begin
      if (dac_now < set_limit) dac_now++;
    end
    rpt.code  = dac_now;
    rpt.v_avg = volt_mean;
    rpt.c_avg = curr_mean;
    rpt.volts = MEAS_W'(volts);
    reports_due.push_back(rpt);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, want %0d got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : check_reports
    dac_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = dac_report_t'(out_tdata[45:0]);
      if (reports_due.size() == 0) begin
        note_mismatch("unrequested result beat, dac_code", 0, got.code);
      end else begin
        want = reports_due.pop_front();
        if (got.code !== want.code)   note_mismatch("dac_code", want.code, got.code);
        if (got.v_avg !== want.v_avg) note_mismatch("avg_voltage_raw", want.v_avg, got.v_avg);
        if (got.c_avg !== want.c_avg) note_mismatch("avg_current_raw", want.c_avg, got.c_avg);
        if (got.volts !== want.volts) note_mismatch("measured_volts", want.volts, got.volts);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall patterns, plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_run_left = 0;

  always @(posedge clk) begin
    if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen <= holdoff_reqs;
      holdoff_left <= HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_tready   <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      if (rx_run_left == 0) begin
        rx_mode     <= rx_mode_t'($urandom_range(0, 3));
        rx_run_left <= $urandom_range(8, 64);
      end else begin
        rx_run_left <= rx_run_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  // Watchdog: any input or config beat restarts the count
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (entered right after a rising edge)
  // ---------------------------------------------------------------------------
  // One input beat. The sender runs in bursts; valid only drops for a gap.
  task automatic send_beat(input logic op, input logic [ADC_W-1:0] smp);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-ADC_W){1'b0}}, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_stepper(op, smp);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, ADC_W'($urandom));
  endtask

  // n samples, biased toward the ends of the ADC range
  task automatic send_samples(input int n);
    logic [ADC_W-1:0] smp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       smp = '0;
        1:       smp = '1;
        default: smp = ADC_W'($urandom);
      endcase
      send_beat(OP_SAMPLE, smp);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET: set_target = val;
      REG_VFS:    set_vfs    = val;
      REG_AFC:    set_afc    = val[ADC_W-1:0];
      REG_LIMIT:  set_limit  = val[ADC_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [REG_W-1:0] tgt, input logic [REG_W-1:0] vfs,
                                input logic [ADC_W-1:0] afc, input logic [ADC_W-1:0] lim);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_VFS, vfs);
    write_reg(REG_AFC, {6'b0, afc});
    write_reg(REG_LIMIT, {6'b0, lim});
  endtask

  // Sender pauses until every pending result is out
  task automatic wait_reports_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Drained, then enough extra cycles for a tick still in the sequencer
  task automatic settle_block();
    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset defaults: empty-channel tick, extreme samples, above target at code 0
  task automatic test_reset_state();
    send_tick();                      // nothing averaged yet, all zero
    send_beat(OP_SAMPLE, 10'd1023);   // voltage
    send_beat(OP_SAMPLE, 10'd0);      // current
    send_tick();                      // 2500 > target 0, code pinned at 0
    send_tick();                      // empty channels keep old averages
    settle_block();
  endtask

  // Climb to the limit, hold above a lowered limit, deadband edges, step down
  task automatic test_code_limits();
    write_all_regs(16'hFFFF, 16'd1023, 10'd1023, 10'd2);  // volts == avg
    repeat (4) send_tick();           // 1, 2, then stuck at the limit
    settle_block();
    write_reg(REG_LIMIT, 16'd0);
    send_tick();                      // code above limit, no raise
    settle_block();
    write_reg(REG_TARGET, 16'd0);
    send_tick();                      // above target: step down
    settle_block();
    write_reg(REG_TARGET, 16'd1024);  // one below: inside deadband
    send_tick();
    settle_block();
    write_reg(REG_TARGET, 16'd1022);  // one above: inside deadband
    send_tick();
    settle_block();
    write_reg(REG_TARGET, 16'd1021);  // just outside: step down
    send_tick();
    settle_block();
  endtask

  // Scaling saturation and a zero divisor
  task automatic test_scaling_edges();
    write_all_regs(16'hFFFF, 16'hFFFF, 10'd1, 10'd1023);
    send_beat(OP_SAMPLE, 10'd1023);
    send_beat(OP_SAMPLE, 10'd5);
    send_tick();                      // product far above 16 bits
    settle_block();
    write_reg(REG_AFC, 16'd0);
    send_tick();
    send_beat(OP_SAMPLE, 10'd0);
    send_beat(OP_SAMPLE, 10'd1023);
    send_tick();
    settle_block();
    write_reg(REG_AFC, 16'd1023);
    write_reg(REG_VFS, 16'd2500);
    send_tick();                      // zero average, code climbs
    settle_block();
  endtask

  // Both windows fill; late max-value samples must be dropped
  task automatic test_full_window();
    send_samples(2 * MAX_SAMPLES_DEF);
    repeat (20) send_beat(OP_SAMPLE, 10'd1023);
    send_tick();
    send_samples(3);                  // alternation continues after the tick
    send_tick();
    settle_block();
  endtask

  // Random phases over a spread of settings, with back-pressure events
  task automatic test_random_phases();
    int tick_pct;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_all_regs(16'($urandom_range(0, 6000)),
                     16'($urandom_range(1, (ph == 5) ? 65535 : 5000)),
                     ADC_W'($urandom_range((ph == 4) ? 0 : 1, 1023)),
                     ADC_W'($urandom_range(0, 1023)));
      tick_pct = (ph == 3) ? 1 : $urandom_range(5, 30);
      if (ph == 1) begin
        // long receiver stall while ticks keep coming: input must back up
        holdoff_reqs++;
        repeat (3) send_tick();
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < tick_pct) send_tick();
        else send_samples(1);
      end
      settle_block();
    end
  endtask

  initial begin
    clear_stepper();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_code_limits();
    test_scaling_edges();
    test_full_window();
    test_random_phases();
    settle_block();
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/avdac_pkg.sv
src/averaged_voltage_dac_stepper_unit.sv
tb/sv/averaged_voltage_dac_stepper_unit_tb.sv
